/* hw/rtl/frbm_pkg.sv */
// Shared types and command codes for the fill-rectangle batch merger.
`timescale 1ns / 1ps

package frbm_pkg;

    localparam logic [3:0] KIND_NONE         = 4'd0;
    localparam logic [3:0] KIND_FILL_RECT    = 4'd1;
    localparam logic [3:0] KIND_STROKE_RECT  = 4'd2;
    localparam logic [3:0] KIND_FILL_CIRCLE  = 4'd3;
    localparam logic [3:0] KIND_STROKE_CIRC  = 4'd4;
    localparam logic [3:0] KIND_TEXT         = 4'd5;
    localparam logic [3:0] KIND_GRADIENT     = 4'd6;
    localparam logic [3:0] KIND_CLIP_START   = 4'd7;
    localparam logic [3:0] KIND_CLIP_END     = 4'd8;

    localparam int KIND_BITS    = 4;
    localparam int DEPTH_BITS   = 16;
    localparam int RADIUS_BITS  = 24;
    localparam int COLOUR_BITS  = 32;
    localparam int WORD64_BITS  = 64;

    typedef struct packed {
        logic displaced;
        logic flushed;
    } t_push;

endpackage

/* hw/rtl/frbm_merge.sv */
// Held command register with the merge decision and bounding-box update.
`timescale 1ns / 1ps

module frbm_merge #(
    parameter int COORD_BITS = 24,
    parameter int DATA_W     = 336
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [DATA_W-1:0] i_data,
    input  logic              i_last,
    output frbm_pkg::t_push   o_push,
    output logic [DATA_W-1:0] o_displaced_data,
    output logic [DATA_W-1:0] o_flushed_data
);
    import frbm_pkg::*;

    localparam int C      = COORD_BITS;
    localparam int SW     = COORD_BITS - 1;
    localparam int EW     = COORD_BITS + 2;
    localparam int O_DEP  = KIND_BITS;
    localparam int O_LEFT = O_DEP + DEPTH_BITS;
    localparam int O_TOP  = O_LEFT + C;
    localparam int O_W    = O_TOP + C;
    localparam int O_H    = O_W + SW;
    localparam int O_RAD  = O_H + SW;
    localparam int O_COL  = O_RAD + RADIUS_BITS;
    localparam int O_SEC  = O_COL + COLOUR_BITS;
    localparam int O_STY  = O_SEC + COLOUR_BITS;
    localparam int O_CON  = O_STY + WORD64_BITS;
    localparam int USED_W = O_CON + WORD64_BITS;

    logic                   r_valid;
    logic [KIND_BITS-1:0]   r_kind;
    logic [DEPTH_BITS-1:0]  r_depth;
    logic [C-1:0]           r_left;
    logic [C-1:0]           r_top;
    logic [SW-1:0]          r_width;
    logic [SW-1:0]          r_height;
    logic [RADIUS_BITS-1:0] r_radius;
    logic [COLOUR_BITS-1:0] r_colour;
    logic [COLOUR_BITS-1:0] r_second;
    logic [WORD64_BITS-1:0] r_style;
    logic [WORD64_BITS-1:0] r_content;

    logic                   n_valid;
    logic [KIND_BITS-1:0]   n_kind;
    logic [DEPTH_BITS-1:0]  n_depth;
    logic [C-1:0]           n_left;
    logic [C-1:0]           n_top;
    logic [SW-1:0]          n_width;
    logic [SW-1:0]          n_height;
    logic [RADIUS_BITS-1:0] n_radius;
    logic [COLOUR_BITS-1:0] n_colour;
    logic [COLOUR_BITS-1:0] n_second;
    logic [WORD64_BITS-1:0] n_style;
    logic [WORD64_BITS-1:0] n_content;

    logic [KIND_BITS-1:0]   in_kind;
    logic [DEPTH_BITS-1:0]  in_depth;
    logic [C-1:0]           in_left;
    logic [C-1:0]           in_top;
    logic [SW-1:0]          in_width;
    logic [SW-1:0]          in_height;
    logic [RADIUS_BITS-1:0] in_radius;
    logic [COLOUR_BITS-1:0] in_colour;
    logic                   merge;
    logic [C-1:0]           mrg_left;
    logic [C-1:0]           mrg_top;
    logic [SW-1:0]          mrg_width;
    logic [SW-1:0]          mrg_height;

    function automatic logic [DATA_W-1:0] pack_cmd(
        input logic [KIND_BITS-1:0]   kind,
        input logic [DEPTH_BITS-1:0]  depth,
        input logic [C-1:0]           left,
        input logic [C-1:0]           top,
        input logic [SW-1:0]          width,
        input logic [SW-1:0]          height,
        input logic [RADIUS_BITS-1:0] radius,
        input logic [COLOUR_BITS-1:0] colour,
        input logic [COLOUR_BITS-1:0] second,
        input logic [WORD64_BITS-1:0] style,
        input logic [WORD64_BITS-1:0] content
    );
        logic [DATA_W-1:0] d;
        d = '0;
        d[0 +: KIND_BITS]        = kind;
        d[O_DEP +: DEPTH_BITS]   = depth;
        d[O_LEFT +: C]           = left;
        d[O_TOP +: C]            = top;
        d[O_W +: SW]             = width;
        d[O_H +: SW]             = height;
        d[O_RAD +: RADIUS_BITS]  = radius;
        d[O_COL +: COLOUR_BITS]  = colour;
        d[O_SEC +: COLOUR_BITS]  = second;
        d[O_STY +: WORD64_BITS]  = style;
        d[O_CON +: WORD64_BITS]  = content;
        return d;
    endfunction

    // Bounding box of two spans on one axis; the extent saturates at the size maximum.
    function automatic logic [C+SW-1:0] merge_axis(
        input logic [C-1:0]  a_lo,
        input logic [SW-1:0] a_len,
        input logic [C-1:0]  b_lo,
        input logic [SW-1:0] b_len
    );
        logic signed [EW-1:0] a0;
        logic signed [EW-1:0] b0;
        logic signed [EW-1:0] a1;
        logic signed [EW-1:0] b1;
        logic signed [EW-1:0] lo;
        logic signed [EW-1:0] hi;
        logic signed [EW-1:0] ext;
        logic signed [EW-1:0] size_max;
        logic [SW-1:0]        len;
        a0 = {{2{a_lo[C-1]}}, a_lo};
        b0 = {{2{b_lo[C-1]}}, b_lo};
        a1 = a0 + {3'b000, a_len};
        b1 = b0 + {3'b000, b_len};
        lo = (a0 < b0) ? a0 : b0;
        hi = (a1 > b1) ? a1 : b1;
        ext = hi - lo;
        size_max = {3'b000, {SW{1'b1}}};
        len = (ext > size_max) ? {SW{1'b1}} : ext[SW-1:0];
        return {lo[C-1:0], len};
    endfunction

    assign in_kind   = i_data[0 +: KIND_BITS];
    assign in_depth  = i_data[O_DEP +: DEPTH_BITS];
    assign in_left   = i_data[O_LEFT +: C];
    assign in_top    = i_data[O_TOP +: C];
    assign in_width  = i_data[O_W +: SW];
    assign in_height = i_data[O_H +: SW];
    assign in_radius = i_data[O_RAD +: RADIUS_BITS];
    assign in_colour = i_data[O_COL +: COLOUR_BITS];

    assign merge = r_valid && (r_kind == KIND_FILL_RECT) && (in_kind == KIND_FILL_RECT)
                   && (r_depth == in_depth) && (r_radius == '0) && (in_radius == '0)
                   && (r_colour == in_colour);

    assign {mrg_left, mrg_width}  = merge_axis(r_left, r_width, in_left, in_width);
    assign {mrg_top, mrg_height}  = merge_axis(r_top, r_height, in_top, in_height);

    always_comb begin
        n_valid   = r_valid;
        n_kind    = r_kind;
        n_depth   = r_depth;
        n_left    = r_left;
        n_top     = r_top;
        n_width   = r_width;
        n_height  = r_height;
        n_radius  = r_radius;
        n_colour  = r_colour;
        n_second  = r_second;
        n_style   = r_style;
        n_content = r_content;
        if (i_accept) begin
            if (merge) begin
                n_left   = mrg_left;
                n_top    = mrg_top;
                n_width  = mrg_width;
                n_height = mrg_height;
            end else begin
                n_kind    = in_kind;
                n_depth   = in_depth;
                n_left    = in_left;
                n_top     = in_top;
                n_width   = in_width;
                n_height  = in_height;
                n_radius  = in_radius;
                n_colour  = in_colour;
                n_second  = i_data[O_SEC +: COLOUR_BITS];
                n_style   = i_data[O_STY +: WORD64_BITS];
                n_content = i_data[O_CON +: WORD64_BITS];
            end
            n_valid = !i_last;
        end
    end

    assign o_push.displaced = i_accept && r_valid && !merge;
    assign o_push.flushed   = i_accept && i_last;

    assign o_displaced_data = pack_cmd(r_kind, r_depth, r_left, r_top, r_width, r_height,
                                       r_radius, r_colour, r_second, r_style, r_content);

    // A flush carries the command as it stands after this transfer has been applied.
    assign o_flushed_data = pack_cmd(n_kind, n_depth, n_left, n_top, n_width, n_height,
                                     n_radius, n_colour, n_second, n_style, n_content);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_depth   <= n_depth;
        r_left    <= n_left;
        r_top     <= n_top;
        r_width   <= n_width;
        r_height  <= n_height;
        r_radius  <= n_radius;
        r_colour  <= n_colour;
        r_second  <= n_second;
        r_style   <= n_style;
        r_content <= n_content;
    end

    if (USED_W > DATA_W) begin : g_width_check
        $error("DATA_W is too narrow for the command fields.");
    end

endmodule

/* hw/rtl/frbm_queue.sv */
// Four-entry result queue that takes up to two results per cycle.
`timescale 1ns / 1ps

module frbm_queue #(
    parameter int DATA_W = 336
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  frbm_pkg::t_push   i_push,
    input  logic [DATA_W-1:0] i_displaced_data,
    input  logic [DATA_W-1:0] i_flushed_data,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data,
    output logic              o_last
);
    import frbm_pkg::*;

    logic [DATA_W:0] r_mem [4];
    logic [1:0]      r_wr_ptr;
    logic [1:0]      r_rd_ptr;
    logic [2:0]      r_count;
    logic [1:0]      n_wr_ptr;
    logic [1:0]      n_rd_ptr;
    logic [2:0]      n_count;
    logic [1:0]      flush_ptr;
    logic            pop;

    assign pop       = i_pop && (r_count != 3'd0);
    assign flush_ptr = r_wr_ptr + {1'b0, i_push.displaced};

    always_comb begin
        n_wr_ptr = r_wr_ptr + {1'b0, i_push.displaced} + {1'b0, i_push.flushed};
        n_rd_ptr = r_rd_ptr + {1'b0, pop};
        n_count  = r_count + {2'b00, i_push.displaced} + {2'b00, i_push.flushed}
                   - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            if (i_push.displaced && (r_wr_ptr == 2'(i))) begin
                r_mem[i] <= {1'b0, i_displaced_data};
            end else if (i_push.flushed && (flush_ptr == 2'(i))) begin
                r_mem[i] <= {1'b1, i_flushed_data};
            end
        end
    end

    // Room for the two results a single transfer can produce.
    assign o_room  = (r_count <= 3'd2);
    assign o_valid = (r_count != 3'd0);
    assign o_data  = r_mem[r_rd_ptr][DATA_W-1:0];
    assign o_last  = r_mem[r_rd_ptr][DATA_W];

endmodule

/* hw/rtl/fill_rect_batch_merger.sv */
// Top level of the fill-rectangle batch merger.
// A result is registered in the result queue and offered on the master side from there.
// Throughput: one command per cycle while the queue has room; a final command with a displaced
// one yields two results, which the queue drains one per cycle while m_axis_tready is high.
// Reset clears the held command and the result queue; no command is held afterward.
`timescale 1ns / 1ps

module fill_rect_batch_merger #(
    parameter int COORD_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // cmd_kind, depth_key, left_x, top_y, box_width, box_height, corner_radius,
    // main_colour, second_colour, style_word, content_ref, then zero fill.
    input  logic [(((234 + 4*COORD_BITS) + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // out_kind, out_depth, out_left, out_top, out_width, out_height, out_radius,
    // out_colour, out_second_colour, out_style, out_content, then zero fill.
    output logic [(((234 + 4*COORD_BITS) + 7) / 8) * 8 - 1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    import frbm_pkg::*;

    localparam int DATA_W = (((234 + 4*COORD_BITS) + 7) / 8) * 8;

    logic              accept;
    logic              room;
    t_push             push;
    logic [DATA_W-1:0] displaced_data;
    logic [DATA_W-1:0] flushed_data;

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    frbm_merge #(
        .COORD_BITS (COORD_BITS),
        .DATA_W     (DATA_W)
    ) u_merge (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data           (s_axis_tdata),
        .i_last           (s_axis_tlast),
        .o_push           (push),
        .o_displaced_data (displaced_data),
        .o_flushed_data   (flushed_data)
    );

    frbm_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .i_displaced_data (displaced_data),
        .i_flushed_data   (flushed_data),
        .o_room           (room),
        .o_valid          (m_axis_tvalid),
        .i_pop            (m_axis_tready),
        .o_data           (m_axis_tdata),
        .o_last           (m_axis_tlast)
    );

endmodule

/* test/fill_rect_batch_merger_checker.sv */
// Checker for the fill-rectangle batch merger: predicts merged commands and compares each transfer.
`timescale 1ns / 1ps

module fill_rect_batch_merger_checker #(
    parameter int COORD_BITS = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_s_tready,
    input  logic [(((234 + 4*COORD_BITS) + 7) / 8) * 8 - 1:0] i_s_tdata,
    input  logic i_s_tlast,
    input  logic i_m_tvalid,
    input  logic i_m_tready,
    input  logic [(((234 + 4*COORD_BITS) + 7) / 8) * 8 - 1:0] i_m_tdata,
    input  logic i_m_tlast,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_commands_in,
    output int   o_commands_out,
    output int   o_merges,
    output int   o_frame_ends
);
    import frbm_pkg::*;

    localparam int PAY_W  = 234 + 4*COORD_BITS;
    localparam int DATA_W = ((PAY_W + 7) / 8) * 8;
    localparam int OFF_DEPTH  = KIND_BITS;
    localparam int OFF_LEFT   = OFF_DEPTH + DEPTH_BITS;
    localparam int OFF_TOP    = OFF_LEFT + COORD_BITS;
    localparam int OFF_WIDTH  = OFF_TOP + COORD_BITS;
    localparam int OFF_HEIGHT = OFF_WIDTH + COORD_BITS - 1;
    localparam int OFF_RADIUS = OFF_HEIGHT + COORD_BITS - 1;
    localparam int OFF_COLOUR = OFF_RADIUS + RADIUS_BITS;
    localparam int OFF_SECOND = OFF_COLOUR + COLOUR_BITS;
    localparam int OFF_STYLE  = OFF_SECOND + COLOUR_BITS;
    localparam int OFF_CONTENT = OFF_STYLE + WORD64_BITS;
    localparam longint SIZE_MAX = (longint'(1) << (COORD_BITS - 1)) - 1;

    typedef struct {
        logic [KIND_BITS-1:0]   kind;
        logic [DEPTH_BITS-1:0]  depth;
        logic [COORD_BITS-1:0]  left;
        logic [COORD_BITS-1:0]  top;
        logic [COORD_BITS-2:0]  width;
        logic [COORD_BITS-2:0]  height;
        logic [RADIUS_BITS-1:0] radius;
        logic [COLOUR_BITS-1:0] colour;
        logic [COLOUR_BITS-1:0] second;
        logic [WORD64_BITS-1:0] style;
        logic [WORD64_BITS-1:0] content;
        logic                   fin;
    } t_draw_cmd;

    t_draw_cmd held_cmd;
    logic      held_valid = 1'b0;
    t_draw_cmd batched_q[$];
    int        fail_count = 0;
    int        commands_in = 0;
    int        commands_out = 0;
    int        merges = 0;
    int        frame_ends = 0;

    assign o_fail_count   = fail_count;
    assign o_commands_in  = commands_in;
    assign o_commands_out = commands_out;
    assign o_merges       = merges;
    assign o_frame_ends   = frame_ends;

    function automatic t_draw_cmd unpack_cmd(logic [DATA_W-1:0] v, logic last);
        t_draw_cmd c;
        c.kind    = v[0 +: KIND_BITS];
        c.depth   = v[OFF_DEPTH +: DEPTH_BITS];
        c.left    = v[OFF_LEFT +: COORD_BITS];
        c.top     = v[OFF_TOP +: COORD_BITS];
        c.width   = v[OFF_WIDTH +: COORD_BITS - 1];
        c.height  = v[OFF_HEIGHT +: COORD_BITS - 1];
        c.radius  = v[OFF_RADIUS +: RADIUS_BITS];
        c.colour  = v[OFF_COLOUR +: COLOUR_BITS];
        c.second  = v[OFF_SECOND +: COLOUR_BITS];
        c.style   = v[OFF_STYLE +: WORD64_BITS];
        c.content = v[OFF_CONTENT +: WORD64_BITS];
        c.fin     = last;
        return c;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            report_mismatch($sformatf("output transfer %0d, %s expected %0h got %0h",
                                      commands_out, name, want, got));
        end
    endtask

    // One axis of the bounding box; the extent saturates at the largest size.
    task automatic widen_axis(input logic [COORD_BITS-1:0] a_lo, input logic [COORD_BITS-2:0] a_len,
                              input logic [COORD_BITS-1:0] b_lo, input logic [COORD_BITS-2:0] b_len,
                              output logic [COORD_BITS-1:0] lo_out,
                              output logic [COORD_BITS-2:0] len_out);
        longint a0, b0, a1, b1, lo, hi, ext;
        a0 = longint'(signed'(a_lo));
        b0 = longint'(signed'(b_lo));
        a1 = a0 + longint'(a_len);
        b1 = b0 + longint'(b_len);
        lo = (a0 < b0) ? a0 : b0;
        hi = (a1 > b1) ? a1 : b1;
        ext = hi - lo;
        if (ext > SIZE_MAX) begin
            ext = SIZE_MAX;
        end
        lo_out  = lo[COORD_BITS-1:0];
        len_out = ext[COORD_BITS-2:0];
    endtask

    task automatic batch_command(input t_draw_cmd c);
        t_draw_cmd out_cmd;
        logic      can_merge;
        can_merge = held_valid && held_cmd.kind == KIND_FILL_RECT && c.kind == KIND_FILL_RECT
                    && held_cmd.depth == c.depth && held_cmd.radius == '0 && c.radius == '0
                    && held_cmd.colour == c.colour;
        if (can_merge) begin
            widen_axis(held_cmd.left, held_cmd.width, c.left, c.width,
                       held_cmd.left, held_cmd.width);
            widen_axis(held_cmd.top, held_cmd.height, c.top, c.height,
                       held_cmd.top, held_cmd.height);
            merges++;
        end else begin
            if (held_valid) begin
                out_cmd = held_cmd;
                out_cmd.fin = 1'b0;
                batched_q.push_back(out_cmd);
            end
            held_cmd = c;
            held_valid = 1'b1;
        end
        if (c.fin) begin
            out_cmd = held_cmd;
            out_cmd.fin = 1'b1;
            batched_q.push_back(out_cmd);
            held_valid = 1'b0;
            frame_ends++;
        end
    endtask

    task automatic check_result(input t_draw_cmd got, input logic [DATA_W-PAY_W-1:0] fill);
        t_draw_cmd want;
        commands_out++;
        if (batched_q.size() == 0) begin
            report_mismatch($sformatf("output transfer %0d arrived with nothing expected",
                                      commands_out));
        end else begin
            want = batched_q.pop_front();
            compare_field("kind", 64'(want.kind), 64'(got.kind));
            compare_field("depth", 64'(want.depth), 64'(got.depth));
            compare_field("left", 64'(want.left), 64'(got.left));
            compare_field("top", 64'(want.top), 64'(got.top));
            compare_field("width", 64'(want.width), 64'(got.width));
            compare_field("height", 64'(want.height), 64'(got.height));
            compare_field("radius", 64'(want.radius), 64'(got.radius));
            compare_field("colour", 64'(want.colour), 64'(got.colour));
            compare_field("second colour", 64'(want.second), 64'(got.second));
            compare_field("style", want.style, got.style);
            compare_field("content", want.content, got.content);
            compare_field("final", 64'(want.fin), 64'(got.fin));
            compare_field("zero fill", 64'd0, 64'(fill));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_valid = 1'b0;
            batched_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                check_result(unpack_cmd(i_m_tdata, i_m_tlast), i_m_tdata[DATA_W-1:PAY_W]);
            end
            if (i_s_tvalid && i_s_tready) begin
                commands_in++;
                batch_command(unpack_cmd(i_s_tdata, i_s_tlast));
            end
        end
        o_pending = batched_q.size();
    end

endmodule

/* test/fill_rect_batch_merger_tb.sv */
// Testbench top for the fill-rectangle batch merger: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module fill_rect_batch_merger_tb;
    import frbm_pkg::*;

    localparam int COORD_BITS      = 24;
    localparam int DATA_W          = (((234 + 4*COORD_BITS) + 7) / 8) * 8;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int HOLD_OFF_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [DATA_W-1:0] s_axis_tdata = '0;  // kind, depth, left, top, width, height, radius,
                                           // colour, second colour, style, content, zero fill
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;       // same fields as s_axis_tdata
    logic m_axis_tlast;

    int fail_count, pending, commands_in, commands_out, merges, frame_ends;
    int send_idle = 0;
    int recv_idle = 0;
    int idle_cycles = 0;
    int hold_off_reqs = 0;
    int hold_offs_done = 0;
    logic [DEPTH_BITS-1:0]  run_depth = '0;
    logic [COLOUR_BITS-1:0] run_colour = '0;

    fill_rect_batch_merger #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast)
    );

    fill_rect_batch_merger_checker #(
        .COORD_BITS(COORD_BITS)
    ) checker_inst (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid),
        .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata),
        .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid),
        .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata),
        .i_m_tlast(m_axis_tlast),
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_commands_in(commands_in),
        .o_commands_out(commands_out),
        .o_merges(merges),
        .o_frame_ends(frame_ends)
    );

    initial begin
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", idle_cycles);
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The long hold-off lets the sender fill the block until it stalls its input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_offs_done < hold_off_reqs) begin
                hold_offs_done++;
                m_axis_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    task automatic drive_transfer(input logic [DATA_W-1:0] data, input logic last);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tdata  = data;
        s_axis_tlast  = last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic send_cmd(input logic [KIND_BITS-1:0] kind, input logic [DEPTH_BITS-1:0] depth,
                            input logic [COORD_BITS-1:0] left, input logic [COORD_BITS-1:0] top,
                            input logic [COORD_BITS-2:0] width,
                            input logic [COORD_BITS-2:0] height,
                            input logic [RADIUS_BITS-1:0] radius,
                            input logic [COLOUR_BITS-1:0] colour,
                            input logic [COLOUR_BITS-1:0] second,
                            input logic [WORD64_BITS-1:0] style,
                            input logic [WORD64_BITS-1:0] content, input logic fin);
        drive_transfer(DATA_W'({content, style, second, colour, radius, height, width, top, left,
                                depth, kind}), fin);
    endtask

    task automatic send_directed();
        send_cmd(KIND_FILL_RECT, 16'h0003, 24'h000100, 24'h000200, 23'd100, 23'd100, '0,
                 32'h11223344, 32'h55667788, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1);
        send_cmd(KIND_FILL_RECT, 16'h8000, 24'h800000, 24'h800000, '0, '0, '0,
                 32'hffffffff, '0, '0, '0, 1'b0);
        send_cmd(KIND_FILL_RECT, 16'h8000, 24'h7fffff, 24'h7fffff, '1, '1, '0,
                 32'hffffffff, '1, '1, '1, 1'b0);
        send_cmd(KIND_FILL_RECT, 16'h8000, 24'h000010, 24'h000010, 23'd16, 23'd16, '0,
                 32'hfffffffe, 32'h0000ffff, 64'h1, 64'h2, 1'b0);
        send_cmd(KIND_FILL_RECT, 16'h8000, 24'h000010, 24'h000010, 23'd16, 23'd16, '1,
                 32'hfffffffe, 32'h0000ffff, 64'h3, 64'h4, 1'b0);
        send_cmd(KIND_FILL_RECT, 16'h8000, 24'h000010, 24'h000010, 23'd16, 23'd16, '0,
                 32'hfffffffe, 32'h0000ffff, 64'h5, 64'h6, 1'b0);
        send_cmd(KIND_FILL_RECT, 16'h7fff, 24'hfffff0, 24'h000020, 23'd32, 23'd8, '0,
                 32'hfffffffe, 32'haaaaaaaa, 64'h7, 64'h8, 1'b0);
        send_cmd(KIND_FILL_RECT, 16'h7fff, 24'h000400, 24'hffff00, '0, '0, '0,
                 32'hfffffffe, 32'h55555555, 64'h9, 64'ha, 1'b0);
        send_cmd(KIND_FILL_RECT, 16'h7fff, 24'h000030, 24'h000030, 23'd4, 23'd4, '0,
                 32'hfffffffe, 32'h12345678, 64'hb, 64'hc, 1'b1);
        send_cmd(KIND_NONE, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        for (int k = 0; k < 16; k++) begin
            if (k != KIND_FILL_RECT) begin
                send_cmd(KIND_BITS'(k), 16'h0040, 24'h000100, 24'h000100, 23'd64, 23'd64, '0,
                         32'h80808080, 32'(k), 64'(k), 64'(k), 1'b0);
            end
        end
        send_cmd(KIND_FILL_RECT, 16'h0040, 24'h000100, 24'h000100, 23'd64, 23'd64, '0,
                 32'h80808080, '0, '0, '0, 1'b1);
    endtask

    // Mostly runs of mergeable fill rectangles, some near misses, some unrelated commands.
    task automatic send_random();
        logic [KIND_BITS-1:0]   kind;
        logic [DEPTH_BITS-1:0]  depth;
        logic [COORD_BITS-1:0]  left, top;
        logic [COORD_BITS-2:0]  width, height;
        logic [RADIUS_BITS-1:0] radius;
        logic [COLOUR_BITS-1:0] colour;
        int mode;
        if ($urandom_range(0, 24) == 0) begin
            run_depth = DEPTH_BITS'($urandom);
        end
        if ($urandom_range(0, 24) == 0) begin
            run_colour = $urandom;
        end
        mode   = $urandom_range(0, 99);
        kind   = KIND_FILL_RECT;
        depth  = run_depth;
        colour = run_colour;
        radius = '0;
        if ($urandom_range(0, 4) == 0) begin
            left   = COORD_BITS'($urandom);
            top    = COORD_BITS'($urandom);
            width  = (COORD_BITS-1)'($urandom);
            height = (COORD_BITS-1)'($urandom);
        end else begin
            left   = COORD_BITS'(int'($urandom_range(0, 4095)) - 2048);
            top    = COORD_BITS'(int'($urandom_range(0, 4095)) - 2048);
            width  = (COORD_BITS-1)'($urandom_range(0, 1023));
            height = (COORD_BITS-1)'($urandom_range(0, 1023));
        end
        if (mode >= 65 && mode < 80) begin
            case ($urandom_range(0, 2))
                0: begin
                    depth = depth ^ (DEPTH_BITS'(1) << $urandom_range(0, DEPTH_BITS - 1));
                end
                1: begin
                    radius = RADIUS_BITS'($urandom_range(1, (1 << RADIUS_BITS) - 1));
                end
                default: begin
                    colour = colour ^ (COLOUR_BITS'(1) << $urandom_range(0, COLOUR_BITS - 1));
                end
            endcase
        end else if (mode >= 80) begin
            kind   = KIND_BITS'($urandom_range(0, 15));
            depth  = ($urandom_range(0, 1) == 0) ? run_depth : DEPTH_BITS'($urandom);
            radius = ($urandom_range(0, 3) == 0) ? '0 : RADIUS_BITS'($urandom);
            colour = ($urandom_range(0, 1) == 0) ? run_colour : COLOUR_BITS'($urandom);
        end
        send_cmd(kind, depth, left, top, width, height, radius, colour, $urandom,
                 {$urandom, $urandom}, {$urandom, $urandom}, $urandom_range(0, 19) == 0);
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle = 30;
        recv_idle = 65;
        send_directed();
        for (int n = 0; n < 300; n++) begin
            if (n == 150) begin
                hold_off_reqs++;
            end
            send_random();
        end

        send_idle = 65;
        recv_idle = 30;
        for (int n = 0; n < 280; n++) begin
            send_random();
        end

        send_idle = 0;
        recv_idle = 0;
        hold_off_reqs++;
        for (int n = 0; n < 270; n++) begin
            send_random();
        end
        send_cmd(KIND_NONE, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b1);
        s_axis_tvalid = 1'b0;
        s_axis_tlast  = 1'b0;

        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (8) @(negedge i_clk);

        $display("run: %0d commands in, %0d merged, %0d commands out, %0d command arrays closed",
                 commands_in, merges, commands_out, frame_ends);
        $display("idle mixes: sender-light/receiver-heavy, the reverse, none; two long output stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/frbm_pkg.sv
hw/rtl/frbm_merge.sv
hw/rtl/frbm_queue.sv
hw/rtl/fill_rect_batch_merger.sv
test/fill_rect_batch_merger_checker.sv
test/fill_rect_batch_merger_tb.sv
